FILE: rtl/lfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_pkg
// shared types and constants of the lfu key/value store
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int unsigned ENTRIES_DEF = 16;
    localparam int unsigned KEY_W       = 32;
    localparam int unsigned VAL_W       = 32;
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned STAMP_W     = 32;
    localparam int unsigned CAP_W       = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic start;
        logic scan;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/lfu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_req_if / lfu_rsp_if
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface lfu_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
    modport source (output valid, kind, key, value, input ready);
    modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lfu_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic signed [31:0] read_value;
    logic        evicted;
    logic signed [31:0] evicted_key;
    modport source (output valid, found, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, found, read_value, evicted, evicted_key, output ready);
endinterface

FILE: rtl/lfu_cache_lookup_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_lookup_update_unit
// fully associative key/value store with least-frequently-used replacement
// ----------------------------------------------------------------------------
// a request is taken in idle; the entry store is then scanned one entry a cycle
//   through its single read port, the last read is drained, and the update writes
//   the response register once it is free; no new request is taken until then
// a new request is taken while the previous response waits to be taken
// synchronous active-low reset clears valid bits, occupancy and stamp counter;
//   capacity resets to 16
module lfu_cache_lookup_update_unit #(
    parameter int unsigned ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    lfu_req_if.sink                   i_req,
    lfu_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0] i_cfg_wdata
);

    lfu_pkg::t_cmd cmd;
    lfu_pkg::t_sts sts;
    logic          req_ready;
    logic [31:0]   rv;
    logic [31:0]   evk;

    assign i_req.ready = req_ready;

    lfu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (sts),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    lfu_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_kind        (i_req.kind),
        .i_key         (i_req.key),
        .i_value       (i_req.value),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_found       (o_rsp.found),
        .o_read_value  (rv),
        .o_evicted     (o_rsp.evicted),
        .o_evicted_key (evk)
    );

    assign o_rsp.read_value  = rv;
    assign o_rsp.evicted_key = evk;

endmodule

FILE: rtl/lfu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_ctrl
// sequencer: accept, scan all entries, drain last read, update and respond
// ----------------------------------------------------------------------------
module lfu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  lfu_pkg::t_sts i_sts,
    output logic          o_req_ready,
    output lfu_pkg::t_cmd o_cmd
);

    lfu_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lfu_pkg::ST_IDLE: begin
                if (i_req_valid) n_state = lfu_pkg::ST_SCAN;
            end
            lfu_pkg::ST_SCAN: begin
                if (i_sts.last) n_state = lfu_pkg::ST_DRAIN;
            end
            lfu_pkg::ST_DRAIN: begin
                n_state = lfu_pkg::ST_UPDATE;
            end
            lfu_pkg::ST_UPDATE: begin
                if (i_sts.out_free) n_state = lfu_pkg::ST_IDLE;
            end
            default: begin
                n_state = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req_ready  = 1'b0;
        o_cmd        = '0;
        case (r_state)
            lfu_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.start = i_req_valid;
            end
            lfu_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            lfu_pkg::ST_UPDATE: begin
                o_cmd.update = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/lfu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_dp
// entry store, sequential scan for hit, free slot and victim, update, response
// ----------------------------------------------------------------------------
module lfu_dp #(
    parameter int unsigned ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lfu_pkg::t_cmd               i_cmd,
    output lfu_pkg::t_sts               o_sts,
    input  logic                        i_cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]   i_cfg_wdata,
    input  logic                        i_kind,
    input  logic [lfu_pkg::KEY_W-1:0]   i_key,
    input  logic [lfu_pkg::VAL_W-1:0]   i_value,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_found,
    output logic [lfu_pkg::VAL_W-1:0]   o_read_value,
    output logic                        o_evicted,
    output logic [lfu_pkg::KEY_W-1:0]   o_evicted_key
);

    localparam int unsigned IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned OW  = $clog2(ENTRIES + 1);
    localparam int unsigned CW  = (OW > lfu_pkg::CAP_W) ? OW : lfu_pkg::CAP_W;
    localparam int unsigned KW  = lfu_pkg::KEY_W;
    localparam int unsigned VW  = lfu_pkg::VAL_W;
    localparam int unsigned NW  = lfu_pkg::CNT_W;
    localparam int unsigned SW  = lfu_pkg::STAMP_W;
    localparam int unsigned MW  = KW + VW + NW + SW;
    localparam logic [CW-1:0]   CAP_LIM  = CW'(ENTRIES);
    localparam logic [IW:0]     LAST_IDX = (IW+1)'(ENTRIES - 1);

    // entry store
    logic [MW-1:0]           r_mem [ENTRIES];
    logic [ENTRIES-1:0]      r_valid;
    logic [lfu_pkg::CAP_W-1:0] r_cap;
    logic [OW-1:0]           r_occ;
    logic [SW-1:0]           r_seq;

    // request
    logic                    r_kind;
    logic [KW-1:0]           r_key;
    logic [VW-1:0]           r_value;

    // scan pipeline
    logic [IW:0]             r_idx;
    logic                    r_rd_vld;
    logic [IW-1:0]           r_rd_idx;
    logic [MW-1:0]           r_rd;

    // scan results
    logic                    r_hit;
    logic [IW-1:0]           r_hit_idx;
    logic [VW-1:0]           r_hit_val;
    logic [NW-1:0]           r_hit_cnt;
    logic [SW-1:0]           r_hit_stamp;
    logic                    r_vic_ok;
    logic [IW-1:0]           r_vic_idx;
    logic [KW-1:0]           r_vic_key;
    logic [NW-1:0]           r_vic_cnt;
    logic [SW-1:0]           r_vic_stamp;
    logic                    r_free_ok;
    logic [IW-1:0]           r_free_idx;

    // response register
    logic                    r_out_vld;
    logic                    r_out_found;
    logic [VW-1:0]           r_out_rv;
    logic                    r_out_ev;
    logic [KW-1:0]           r_out_evk;

    logic [KW-1:0]           rd_key;
    logic [VW-1:0]           rd_val;
    logic [NW-1:0]           rd_cnt;
    logic [SW-1:0]           rd_stamp;
    logic                    rd_live;
    logic                    rd_better;

    logic [CW-1:0]           cap_eff;
    logic                    raise;
    logic [NW-1:0]           cnt_up;
    logic                    wr_en;
    logic [IW-1:0]           wr_slot;
    logic [MW-1:0]           wr_word;
    logic                    ins;
    logic                    occ_inc;
    logic                    seq_inc;
    logic                    n_found;
    logic [VW-1:0]           n_rv;
    logic                    n_ev;
    logic [KW-1:0]           n_evk;

    assign {rd_key, rd_val, rd_cnt, rd_stamp} = r_rd;
    assign rd_live   = r_rd_vld && r_valid[r_rd_idx];
    assign rd_better = !r_vic_ok || (rd_cnt < r_vic_cnt) ||
                       ((rd_cnt == r_vic_cnt) && (rd_stamp < r_vic_stamp));

    assign o_sts.last     = (r_idx == LAST_IDX);
    assign o_sts.out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd <= r_mem[r_idx[IW-1:0]];
        end
        if (wr_en) begin
            r_mem[wr_slot] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind  <= i_kind;
            r_key   <= i_key;
            r_value <= i_value;
        end
        r_rd_idx <= r_idx[IW-1:0];
        if (rd_live && !r_hit && rd_key == r_key) begin
            r_hit_idx   <= r_rd_idx;
            r_hit_val   <= rd_val;
            r_hit_cnt   <= rd_cnt;
            r_hit_stamp <= rd_stamp;
        end
        if (rd_live && rd_better) begin
            r_vic_idx   <= r_rd_idx;
            r_vic_key   <= rd_key;
            r_vic_cnt   <= rd_cnt;
            r_vic_stamp <= rd_stamp;
        end
        if (r_rd_vld && !r_valid[r_rd_idx] && !r_free_ok) begin
            r_free_idx <= r_rd_idx;
        end
        if (i_cmd.update) begin
            r_out_found <= n_found;
            r_out_rv    <= n_rv;
            r_out_ev    <= n_ev;
            r_out_evk   <= n_evk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_cap     <= lfu_pkg::CAP_RESET;
            r_occ     <= '0;
            r_seq     <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_vic_ok  <= 1'b0;
            r_free_ok <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.start) begin
                r_idx     <= '0;
                r_hit     <= 1'b0;
                r_vic_ok  <= 1'b0;
                r_free_ok <= 1'b0;
            end else begin
                if (i_cmd.scan) r_idx <= r_idx + 1'b1;
                if (rd_live && rd_key == r_key) r_hit <= 1'b1;
                if (rd_live) r_vic_ok <= 1'b1;
                if (r_rd_vld && !r_valid[r_rd_idx]) r_free_ok <= 1'b1;
            end
            if (i_cmd.update) begin
                if (ins) r_valid[wr_slot] <= 1'b1;
                if (occ_inc) r_occ <= r_occ + 1'b1;
                if (seq_inc) r_seq <= r_seq + 1'b1;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        cap_eff = (CW'(r_cap) > CAP_LIM) ? CAP_LIM : CW'(r_cap);
        raise   = (r_hit_cnt < lfu_pkg::COUNT_MAX);
        cnt_up  = raise ? r_hit_cnt + 1'b1 : r_hit_cnt;
        wr_en   = 1'b0;
        wr_slot = r_hit_idx;
        wr_word = {r_key, r_hit_val, cnt_up, raise ? r_seq : r_hit_stamp};
        ins     = 1'b0;
        occ_inc = 1'b0;
        seq_inc = 1'b0;
        n_found = r_hit;
        n_rv    = '0;
        n_ev    = 1'b0;
        n_evk   = '0;
        if (r_kind == lfu_pkg::KIND_GET) begin
            n_rv = r_hit ? r_hit_val : '1;
            if (r_hit) begin
                wr_en   = raise;
                seq_inc = raise;
            end
        end else if (cap_eff != '0) begin
            if (r_hit) begin
                wr_en   = 1'b1;
                seq_inc = raise;
                wr_word = {r_key, r_value, cnt_up, raise ? r_seq : r_hit_stamp};
            end else begin
                wr_word = {r_key, r_value, NW'(1), r_seq};
                if (CW'(r_occ) >= cap_eff && r_vic_ok) begin
                    wr_slot = r_vic_idx;
                    n_ev    = 1'b1;
                    n_evk   = r_vic_key;
                    ins     = 1'b1;
                end else if (r_free_ok) begin
                    wr_slot = r_free_idx;
                    occ_inc = 1'b1;
                    ins     = 1'b1;
                end else if (r_vic_ok) begin
                    wr_slot = r_vic_idx;
                    ins     = 1'b1;
                end
                wr_en   = ins;
                seq_inc = ins;
            end
        end
        wr_en = wr_en && i_cmd.update;
    end

    assign o_out_valid   = r_out_vld;
    assign o_found       = r_out_found;
    assign o_read_value  = r_out_rv;
    assign o_evicted     = r_out_ev;
    assign o_evicted_key = r_out_evk;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(ENTRIES))
        else $error("occupancy beyond entry count");

    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_ev) |-> !r_out_found)
        else $error("eviction reported on a hit");

    a_update_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> (!r_out_vld || i_out_ready))
        else $error("response overwritten before taken");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.update |=> (r_occ == $past(r_occ)))
        else $error("occupancy changed outside update");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// bench for the lfu key/value store: a table of directed requests and capacity
// cases, then bursts of random get/put traffic over a small key set, each response
// checked against a behavioural predictor or its table row across several capacity settings
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N = 16;
    localparam int LAT = N + 3;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic        found;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } t_rsp;

    typedef struct {
        logic        kind;
        logic [31:0] key;
        logic [31:0] value;
        logic        known;
        t_rsp        rsp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [lfu_pkg::CAP_W-1:0] i_cfg_wdata = '0;

    lfu_req_if req ();
    lfu_rsp_if rsp ();

    lfu_cache_lookup_update_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req.sink),
        .o_rsp      (rsp.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [4:0]  cap_reg;
    logic        slot_valid [N];
    logic [31:0] slot_key [N];
    logic [31:0] slot_val [N];
    logic [15:0] slot_cnt [N];
    logic [31:0] slot_stamp [N];
    logic [31:0] seq_ctr;
    logic [4:0]  fill;

    t_rsp pending_rsps [$];
    logic pending_known [$];
    t_rsp known_rsps [$];
    int   errors = 0;
    longint cycles = 0;
    int   key_pool [8];

    function automatic int find_slot(logic [31:0] k);
        for (int i = 0; i < N; i++)
            if (slot_valid[i] && slot_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int lfu_victim();
        int b;
        b = -1;
        for (int i = 0; i < N; i++) begin
            if (!slot_valid[i]) continue;
            if (b < 0 || slot_cnt[i] < slot_cnt[b] ||
                (slot_cnt[i] == slot_cnt[b] && slot_stamp[i] < slot_stamp[b])) b = i;
        end
        return b;
    endfunction

    function automatic void bump(int i);
        if (slot_cnt[i] != lfu_pkg::COUNT_MAX) begin
            slot_cnt[i]++;
            slot_stamp[i] = seq_ctr;
            seq_ctr++;
        end
    endfunction

    function automatic t_rsp predict_access(logic kind, logic [31:0] k, logic [31:0] v);
        t_rsp r;
        int hit, s;
        logic [4:0] ecap;
        ecap = (cap_reg > N) ? 5'(N) : cap_reg;
        hit = find_slot(k);
        r = '0;
        r.found = (hit >= 0);
        if (kind == lfu_pkg::KIND_GET) begin
            if (hit >= 0) begin
                r.read_value = slot_val[hit];
                bump(hit);
            end else begin
                r.read_value = '1;
            end
        end else if (ecap != 0) begin
            if (hit >= 0) begin
                slot_val[hit] = v;
                bump(hit);
            end else begin
                s = -1;
                if (fill >= ecap) s = lfu_victim();
                if (s >= 0) begin
                    r.evicted = 1'b1;
                    r.evicted_key = slot_key[s];
                end else begin
                    for (int i = N - 1; i >= 0; i--) if (!slot_valid[i]) s = i;
                    if (s < 0) s = lfu_victim();
                    else fill++;
                end
                slot_valid[s] = 1'b1;
                slot_key[s] = k;
                slot_val[s] = v;
                slot_cnt[s] = 16'd1;
                slot_stamp[s] = seq_ctr;
                seq_ctr++;
            end
        end
        return r;
    endfunction

    function automatic void clear_store();
        cap_reg = lfu_pkg::CAP_RESET;
        for (int i = 0; i < N; i++) begin
            slot_valid[i] = 1'b0;
            slot_cnt[i] = '0;
            slot_stamp[i] = '0;
        end
        seq_ctr = '0;
        fill = '0;
    endfunction

    // response side: stall pattern and checking
    int stall_mode = 0;
    always @(negedge i_clk) begin
        case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            default: rsp.ready <= ($urandom_range(0, 3) == 0);
        endcase
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    end

    always @(posedge i_clk) begin
        t_rsp got, want;
        logic kn;
        cycles <= cycles + 1;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            got = {rsp.found, rsp.read_value, rsp.evicted, rsp.evicted_key};
            if (pending_rsps.size() == 0) begin
                $display("%0t unexpected response %h", $time, got);
                errors++;
            end else begin
                want = pending_rsps.pop_front();
                kn = pending_known.pop_front();
                if (kn) want = known_rsps.pop_front();
                if (got.found !== want.found)
                    $display("%0t found exp %b got %b", $time, want.found, got.found);
                if (got.read_value !== want.read_value)
                    $display("%0t read_value exp %h got %h", $time,
                             want.read_value, got.read_value);
                if (got.evicted !== want.evicted)
                    $display("%0t evicted exp %b got %b", $time, want.evicted, got.evicted);
                if (got.evicted_key !== want.evicted_key)
                    $display("%0t evicted_key exp %h got %h", $time,
                             want.evicted_key, got.evicted_key);
                if (got !== want) errors++;
            end
        end
    end

    initial begin
        @(posedge i_clk);
        while (cycles < LIMIT) @(posedge i_clk);
        $display("tb_top failed");
        $finish;
    end

    // request side
    task automatic send(logic kind, logic [31:0] k, logic [31:0] v,
                        logic known, t_rsp exp_rsp);
        t_rsp p;
        req.kind <= kind;
        req.key <= k;
        req.value <= v;
        req.valid <= 1'b1;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        p = predict_access(kind, k, v);
        if (known && p !== exp_rsp) begin
            $display("%0t table row exp %h predictor %h", $time, exp_rsp, p);
            errors++;
        end
        pending_rsps.push_back(p);
        pending_known.push_back(known);
        if (known) known_rsps.push_back(exp_rsp);
        @(negedge i_clk);
    endtask

    task automatic idle(int n);
        req.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_rsps.size() != 0) @(negedge i_clk);
        repeat (LAT + 4) @(negedge i_clk);
    endtask

    task automatic set_capacity(logic [4:0] c);
        drain();
        i_cfg_wdata <= c;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cap_reg = c;
        @(negedge i_clk);
    endtask

    function automatic t_rsp mk(logic f, logic [31:0] rv, logic e, logic [31:0] ek);
        t_rsp r;
        r.found = f;
        r.read_value = rv;
        r.evicted = e;
        r.evicted_key = ek;
        return r;
    endfunction

    function automatic logic [31:0] pick_key();
        int s;
        s = $urandom_range(0, 15);
        if (s < 12) return key_pool[$urandom_range(0, 7)];
        if (s < 14) return $urandom_range(0, 40);
        return $urandom;
    endfunction

    t_row dir_rows [$];

    initial begin
        logic [4:0] caps [7];
        int burst, sent;
        req.valid = 1'b0;
        req.kind = lfu_pkg::KIND_GET;
        req.key = '0;
        req.value = '0;
        clear_store();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        dir_rows = '{
            '{lfu_pkg::KIND_GET, 32'h0000_0000, 32'h0, 1'b1,
              mk(1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0)},
            '{lfu_pkg::KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
              mk(1'b0, 32'h0, 1'b0, 32'h0)},
            '{lfu_pkg::KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
              mk(1'b0, 32'h0, 1'b0, 32'h0)},
            '{lfu_pkg::KIND_GET, 32'h8000_0000, 32'h0, 1'b1,
              mk(1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0)},
            '{lfu_pkg::KIND_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              mk(1'b1, 32'h8000_0000, 1'b0, 32'h0)},
            '{lfu_pkg::KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              mk(1'b0, 32'h0, 1'b0, 32'h0)},
            '{lfu_pkg::KIND_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
              mk(1'b1, 32'h0, 1'b0, 32'h0)},
            '{lfu_pkg::KIND_GET, 32'hFFFF_FFFF, 32'h0, 1'b1,
              mk(1'b1, 32'h0, 1'b0, 32'h0)},
            '{lfu_pkg::KIND_GET, 32'h0000_0001, 32'h0, 1'b1,
              mk(1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0)}
        };
        foreach (dir_rows[i])
            send(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].value,
                 dir_rows[i].known, dir_rows[i].rsp);

        // capacity 2: eviction on a count tie broken by stamp, then eviction by count
        set_capacity(5'd2);
        send(lfu_pkg::KIND_PUT, 32'd10, 32'd100, 1'b0, '0);
        send(lfu_pkg::KIND_PUT, 32'd11, 32'd110, 1'b0, '0);
        send(lfu_pkg::KIND_PUT, 32'd12, 32'd120, 1'b0, '0);
        send(lfu_pkg::KIND_GET, 32'd12, 32'd0, 1'b0, '0);
        send(lfu_pkg::KIND_PUT, 32'd13, 32'd130, 1'b0, '0);
        send(lfu_pkg::KIND_PUT, 32'd14, 32'd140, 1'b0, '0);
        // capacity 0: puts ignored, gets still hit
        set_capacity(5'd0);
        send(lfu_pkg::KIND_PUT, 32'd20, 32'd1, 1'b0, '0);
        send(lfu_pkg::KIND_PUT, 32'd12, 32'd9, 1'b1, mk(1'b1, 32'h0, 1'b0, 32'h0));
        send(lfu_pkg::KIND_GET, 32'd20, 32'd0, 1'b1,
             mk(1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0));
        send(lfu_pkg::KIND_GET, 32'd12, 32'd0, 1'b0, '0);
        // above entries: clamps to 16
        set_capacity(5'd31);
        for (int i = 0; i < 18; i++)
            send(lfu_pkg::KIND_PUT, 32'd200 + i, $urandom, 1'b0, '0);

        // random traffic over a small key pool
        set_capacity(5'd16);
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom_range(0, 3) == 0 ? $urandom : i * 3;
        caps = '{5'd16, 5'd3, 5'd1, 5'd8, 5'd0, 5'd31, 5'd5};
        sent = 0;
        for (int ph = 0; ph < 7; ph++) begin
            if (ph != 0) set_capacity(caps[ph]);
            for (int n = 0; n < 90; n++) begin
                if (n == 45) drain();
                if ($urandom_range(0, 3) == 0) idle($urandom_range(1, 12));
                burst = $urandom_range(1, 6);
                for (int b = 0; b < burst; b++) begin
                    send(1'($urandom_range(0, 1)), pick_key(), $urandom, 1'b0, '0);
                    sent++;
                end
                n += burst - 1;
            end
        end
        // shrink below occupancy after filling
        set_capacity(5'd16);
        for (int i = 0; i < 16; i++) send(lfu_pkg::KIND_PUT, 32'd500 + i, i, 1'b0, '0);
        set_capacity(5'd4);
        for (int i = 0; i < 10; i++)
            send(1'($urandom_range(0, 1)), pick_key(), $urandom, 1'b0, '0);

        drain();
        if (errors == 0 && pending_rsps.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
